FILE: hw/rtl/difference_hash_box_downsample_defines.svh
// Assertion shorthands for the difference hash block
`ifndef DIFFERENCE_HASH_BOX_DOWNSAMPLE_DEFINES_SVH
`define DIFFERENCE_HASH_BOX_DOWNSAMPLE_DEFINES_SVH

// Check a consequence in the same cycle
`define DHBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the following cycle
`define DHBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dhash_pkg.sv
`default_nettype none

package dhash_pkg;

  // Default sizes
  localparam int unsigned DEF_MAX_WIDTH    = 4096;
  localparam int unsigned DEF_MAX_HEIGHT   = 4096;
  localparam int unsigned DEF_GRID_COLUMNS = 9;
  localparam int unsigned DEF_GRID_ROWS    = 8;

  // Register and pixel formats
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned PIX_MAX = (1 << PIX_W) - 1;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_SETUP,
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_FRD,
    ST_FLOAD,
    ST_FWAIT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/difference_hash_box_downsample.sv
`default_nettype none

// Channel     Direction  Handshake                     Payload
// config      in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
// pixel       in         start high, busy low          gray_pixel_i
// hash        out        hash_valid_o, one cycle       hash_value_o
//
// Pixels are taken one per cycle while busy is low: each updates one bin sum in the
// bin memory by a read-modify-write, with forwarding when two pixels in a row hit the
// same entry. After the last pixel busy stays high while one iterative divide per
// bin runs. The hash then shows for one cycle, and a clearing pass over all bins
// follows. Reset and every register write run a setup (box size by reciprocal
// multiply) plus that clearing pass. The receiver cannot stall the hash.
module difference_hash_box_downsample import dhash_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int unsigned GRID_COLUMNS = DEF_GRID_COLUMNS,
  parameter int unsigned GRID_ROWS    = DEF_GRID_ROWS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [APB_AW-1:0]                     paddr,
  input  logic [APB_DW-1:0]                     pwdata,
  output logic [APB_DW-1:0]                     prdata,
  output logic                                  pready,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [PIX_W-1:0]                      gray_pixel_i,
  output logic                                  hash_valid_o,
  output logic [(GRID_COLUMNS-1)*GRID_ROWS-1:0] hash_value_o
);

  localparam int unsigned N       = GRID_COLUMNS;
  localparam int unsigned M       = GRID_ROWS;
  localparam int unsigned EFF_MW  = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
  localparam int unsigned EFF_MH  = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
  localparam int unsigned WD      = $clog2(EFF_MW + 1);
  localparam int unsigned HD      = $clog2(EFF_MH + 1);
  localparam int unsigned DVW     = (WD > HD) ? WD : HD;
  localparam int unsigned SIW     = 1;
  localparam int unsigned NSH     = DVW + $clog2(N);
  localparam int unsigned MSH     = DVW + $clog2(M);
  localparam longint unsigned NREC = ((64'd1 << NSH) + N - 1) / N;
  localparam longint unsigned MREC = ((64'd1 << MSH) + M - 1) / M;
  localparam longint unsigned COLBOX = EFF_MW / N + 1;
  localparam longint unsigned ROWBOX = EFF_MH / M + 1;
  localparam int unsigned CBW     = $clog2(COLBOX + 1);
  localparam int unsigned RBW     = $clog2(ROWBOX + 1);
  localparam int unsigned CW      = $clog2(COLBOX * ROWBOX + 1);
  localparam int unsigned SUMW    = $clog2(PIX_MAX * COLBOX * ROWBOX + 1);
  localparam int unsigned CPW     = $clog2(N);
  localparam int unsigned RPW     = (M > 1) ? $clog2(M) : 1;
  localparam int unsigned P       = N * M;
  localparam int unsigned AW      = $clog2(P);
  localparam int unsigned EWW     = $clog2(N * EFF_MW + 1);
  localparam int unsigned EHW     = $clog2(M * EFF_MH + 1);
  localparam int unsigned NRW     = $clog2(N + 1);
  localparam int unsigned MRW     = $clog2(M + 1);
  localparam int unsigned HASH_W  = (N - 1) * M;

  state_e state_q, state_d;

  logic [CFG_W-1:0] cfg_w_q, cfg_w_d, cfg_h_q, cfg_h_d;
  logic             cfg_wr;
  reg_idx_e         ridx;
  logic [WD-1:0]    img_w;
  logic [HD-1:0]    img_h;
  logic             narrow_w, narrow_h;

  // Setup: box size quotient and remainder
  logic [SIW-1:0] sc_q, sc_d;
  logic [WD-1:0]  qw_q, qw_d;
  logic [HD-1:0]  qh_q, qh_d;
  logic [NRW-1:0] rw_q, rw_d;
  logic [MRW-1:0] rh_q, rh_d;
  logic [DVW-1:0] w_ext, h_ext;
  logic [NSH+DVW:0] w_prod;
  logic [MSH+DVW:0] h_prod;
  logic [WD-1:0]  qw_c;
  logic [HD-1:0]  qh_c;

  logic [AW-1:0] clr_q, clr_d;

  // Pixel position tracking
  logic [WD-1:0]  x_q, x_d;
  logic [EWW-1:0] t_q, t_d, e_q, e_d;
  logic [CPW-1:0] k_q, k_d;
  logic [HD-1:0]  y_q, y_d;
  logic [EHW-1:0] u_q, u_d, f_q, f_d;
  logic [RPW-1:0] kr_q, kr_d;
  logic [EWW:0]   t_next;
  logic [EHW:0]   u_next;
  logic           col_last, frame_end, accept;
  logic [CPW-1:0] sp_c;
  logic [RPW-1:0] sp_r;
  logic [AW-1:0]  st_addr;

  // Accumulate stage
  logic            s2_vld_q, s2_vld_d, fwd_q, fwd_d;
  logic [AW-1:0]   s2_addr_q, s2_addr_d;
  logic [PIX_W-1:0] s2_pix_q, s2_pix_d;
  logic [SUMW-1:0] lastw_q, lastw_d, wsum;

  // Finish pass
  logic [CPW-1:0]  ci_q, ci_d;
  logic [WD-1:0]   ca_q, ca_d;
  logic [NRW-1:0]  cr_q, cr_d;
  logic [RPW-1:0]  rj_q, rj_d;
  logic [HD-1:0]   ra_q, ra_d;
  logic [MRW-1:0]  rr_q, rr_d;
  logic [NRW:0]    c_rsum;
  logic [MRW:0]    r_rsum;
  logic            ccarry, rcarry;
  logic [WD-1:0]   colw_sum;
  logic [HD-1:0]   rowh_sum;
  logic [CBW-1:0]  colw;
  logic [RBW-1:0]  rowh;
  logic [CBW+RBW-1:0] prod;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CPW-1:0]  cp_f;
  logic [RPW-1:0]  rp_f;
  logic [AW-1:0]   faddr;
  logic [SUMW-1:0] prev_q, prev_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic            last_bin;

  // Memory and divider ports
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [SUMW-1:0] mem_wdata, mem_rdata;
  logic            div_start, div_done;
  logic [SUMW-1:0] div_quo;

  // Configuration port
  assign cfg_wr = psel & penable & pwrite & pready;
  assign ridx   = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_w_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_h_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg_w_d = cfg_w_q;
    cfg_h_d = cfg_h_q;
    if (cfg_wr) begin
      unique case (ridx)
        REG_IMAGE_WIDTH:  cfg_w_d = pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: cfg_h_d = pwdata[CFG_W-1:0];
        default:          cfg_w_d = cfg_w_q;
      endcase
    end
  end

  // Clamp sizes to the supported range
  always_comb begin
    if (cfg_w_q == '0) begin
      img_w = WD'(1);
    end else if (32'(cfg_w_q) > EFF_MW) begin
      img_w = WD'(EFF_MW);
    end else begin
      img_w = WD'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      img_h = HD'(1);
    end else if (32'(cfg_h_q) > EFF_MH) begin
      img_h = HD'(EFF_MH);
    end else begin
      img_h = HD'(cfg_h_q);
    end
  end

  assign narrow_w = (32'(img_w) < N);
  assign narrow_h = (32'(img_h) < M);

  // Setup quotient: size by grid count through a reciprocal multiply
  assign w_ext  = DVW'(img_w);
  assign h_ext  = DVW'(img_h);
  assign w_prod = (NSH + DVW + 1)'(w_ext) * (NSH + DVW + 1)'(NREC);
  assign h_prod = (MSH + DVW + 1)'(h_ext) * (MSH + DVW + 1)'(MREC);
  assign qw_c   = WD'(w_prod >> NSH);
  assign qh_c   = HD'(h_prod >> MSH);

  // Pixel position and bin address of the incoming pixel
  assign accept    = start & ~busy;
  assign col_last  = (32'(x_q) + 1 == 32'(img_w));
  assign frame_end = col_last & (32'(y_q) + 1 == 32'(img_h));
  assign t_next    = (EWW + 1)'(t_q) + (EWW + 1)'(N);
  assign u_next    = (EHW + 1)'(u_q) + (EHW + 1)'(M);
  assign sp_c      = narrow_w ? CPW'(x_q) : k_q;
  assign sp_r      = narrow_h ? RPW'(y_q) : kr_q;
  assign st_addr   = AW'(32'(sp_r) * N + 32'(sp_c));

  // Accumulate with forwarding from the previous write
  assign wsum = (fwd_q ? lastw_q : mem_rdata) + SUMW'(s2_pix_q);

  // Box geometry of the current bin in the finish pass
  assign c_rsum   = (NRW + 1)'(cr_q) + (NRW + 1)'(rw_q);
  assign r_rsum   = (MRW + 1)'(rr_q) + (MRW + 1)'(rh_q);
  assign ccarry   = (32'(c_rsum) >= N);
  assign rcarry   = (32'(r_rsum) >= M);
  assign colw_sum = qw_q + WD'(ccarry);
  assign rowh_sum = qh_q + HD'(rcarry);
  assign colw     = (colw_sum == '0) ? CBW'(1) : CBW'(colw_sum);
  assign rowh     = (rowh_sum == '0) ? RBW'(1) : RBW'(rowh_sum);
  assign prod     = (CBW + RBW)'(colw) * (CBW + RBW)'(rowh);
  assign cp_f     = narrow_w ? CPW'(ca_q) : ci_q;
  assign rp_f     = narrow_h ? RPW'(ra_q) : rj_q;
  assign faddr    = AW'(32'(rp_f) * N + 32'(cp_f));
  assign last_bin = (32'(ci_q) == N - 1) & (32'(rj_q) == M - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    priority if (cfg_wr) begin
      state_d = ST_SETUP;
    end else begin
      unique case (state_q)
        ST_SETUP: if (sc_q == SIW'(1)) state_d = ST_CLEAR;
        ST_CLEAR: if (32'(clr_q) == P - 1) state_d = ST_RUN;
        ST_RUN:   if (accept && frame_end) state_d = ST_DRAIN;
        ST_DRAIN: state_d = ST_FRD;
        ST_FRD:   state_d = ST_FLOAD;
        ST_FLOAD: state_d = ST_FWAIT;
        ST_FWAIT: begin
          if (div_done) state_d = last_bin ? ST_EMIT : ST_FRD;
        end
        ST_EMIT:  state_d = ST_CLEAR;
        default:  state_d = ST_SETUP;
      endcase
    end
  end

  // Outputs and memory control
  always_comb begin
    busy         = (state_q != ST_RUN);
    hash_valid_o = (state_q == ST_EMIT);
    div_start    = (state_q == ST_FLOAD);
    mem_re       = 1'b0;
    mem_raddr    = st_addr;
    mem_we       = 1'b0;
    mem_waddr    = s2_addr_q;
    mem_wdata    = wsum;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (s2_vld_q) begin
      mem_we = 1'b1;
    end
    if (state_q == ST_FRD) begin
      mem_re    = 1'b1;
      mem_raddr = faddr;
    end else if (accept) begin
      mem_re = 1'b1;
    end
  end

  // Datapath next values
  always_comb begin
    sc_d = sc_q;  qw_d = qw_q;  qh_d = qh_q;  rw_d = rw_q;  rh_d = rh_q;
    clr_d = clr_q;
    x_d = x_q;  t_d = t_q;  e_d = e_q;  k_d = k_q;
    y_d = y_q;  u_d = u_q;  f_d = f_q;  kr_d = kr_q;
    s2_vld_d  = accept;
    s2_addr_d = st_addr;
    s2_pix_d  = gray_pixel_i;
    fwd_d     = accept & s2_vld_q & (s2_addr_q == st_addr);
    lastw_d   = s2_vld_q ? wsum : lastw_q;
    ci_d = ci_q;  ca_d = ca_q;  cr_d = cr_q;
    rj_d = rj_q;  ra_d = ra_q;  rr_d = rr_q;
    cnt_d  = cnt_q;
    prev_d = prev_q;
    hash_d = hash_q;

    if (cfg_wr) begin
      // restart setup on any write
      sc_d = '0;  qw_d = '0;  qh_d = '0;  rw_d = '0;  rh_d = '0;
      clr_d = '0;
    end else begin
      unique case (state_q)
        ST_SETUP: begin
          // quotient first, then the remainder from the registered quotient
          sc_d = sc_q + 1'b1;
          if (sc_q == '0) begin
            qw_d = qw_c;
            qh_d = qh_c;
          end else begin
            rw_d = NRW'(32'(img_w) - 32'(qw_q) * N);
            rh_d = MRW'(32'(img_h) - 32'(qh_q) * M);
          end
          clr_d = '0;
        end
        ST_CLEAR: begin
          // sweep the bins and rewind the position and finish counters
          clr_d = clr_q + 1'b1;
          x_d = '0;  t_d = EWW'(N);  e_d = EWW'(img_w);  k_d = '0;
          y_d = '0;  u_d = EHW'(M);  f_d = EHW'(img_h);  kr_d = '0;
          ci_d = '0;  ca_d = '0;  cr_d = '0;
          rj_d = '0;  ra_d = '0;  rr_d = '0;
        end
        ST_RUN: begin
          if (accept) begin
            if (col_last) begin
              x_d = '0;  t_d = EWW'(N);  e_d = EWW'(img_w);  k_d = '0;
              y_d = y_q + 1'b1;
              u_d = EHW'(u_next);
              if (u_next > (EHW + 1)'(f_q)) begin
                kr_d = kr_q + 1'b1;
                f_d  = f_q + EHW'(img_h);
              end
            end else begin
              x_d = x_q + 1'b1;
              t_d = EWW'(t_next);
              if (t_next > (EWW + 1)'(e_q)) begin
                k_d = k_q + 1'b1;
                e_d = e_q + EWW'(img_w);
              end
            end
          end
        end
        ST_FRD: begin
          cnt_d = CW'(prod);
        end
        ST_FWAIT: begin
          if (div_done) begin
            prev_d = div_quo;
            if (ci_q != '0) begin
              hash_d = HASH_W'({hash_q, (prev_q > div_quo)});
            end
            if (32'(ci_q) == N - 1) begin
              ci_d = '0;  ca_d = '0;  cr_d = '0;
              rj_d = rj_q + 1'b1;
              ra_d = ra_q + rowh_sum;
              rr_d = rcarry ? MRW'(32'(r_rsum) - M) : MRW'(r_rsum);
            end else begin
              ci_d = ci_q + 1'b1;
              ca_d = ca_q + colw_sum;
              cr_d = ccarry ? NRW'(32'(c_rsum) - N) : NRW'(c_rsum);
            end
          end
        end
        ST_EMIT: begin
          clr_d = '0;
        end
        default: begin
          clr_d = clr_q;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SETUP;
      cfg_w_q  <= CFG_W'(1);
      cfg_h_q  <= CFG_W'(1);
      sc_q     <= '0;
      qw_q     <= '0;
      qh_q     <= '0;
      rw_q     <= '0;
      rh_q     <= '0;
      clr_q    <= '0;
      x_q      <= '0;
      t_q      <= '0;
      e_q      <= '0;
      k_q      <= '0;
      y_q      <= '0;
      u_q      <= '0;
      f_q      <= '0;
      kr_q     <= '0;
      s2_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      ci_q     <= '0;
      ca_q     <= '0;
      cr_q     <= '0;
      rj_q     <= '0;
      ra_q     <= '0;
      rr_q     <= '0;
    end else begin
      state_q  <= state_d;
      cfg_w_q  <= cfg_w_d;
      cfg_h_q  <= cfg_h_d;
      sc_q     <= sc_d;
      qw_q     <= qw_d;
      qh_q     <= qh_d;
      rw_q     <= rw_d;
      rh_q     <= rh_d;
      clr_q    <= clr_d;
      x_q      <= x_d;
      t_q      <= t_d;
      e_q      <= e_d;
      k_q      <= k_d;
      y_q      <= y_d;
      u_q      <= u_d;
      f_q      <= f_d;
      kr_q     <= kr_d;
      s2_vld_q <= s2_vld_d;
      fwd_q    <= fwd_d;
      ci_q     <= ci_d;
      ca_q     <= ca_d;
      cr_q     <= cr_d;
      rj_q     <= rj_d;
      ra_q     <= ra_d;
      rr_q     <= rr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s2_addr_q <= s2_addr_d;
    s2_pix_q  <= s2_pix_d;
    lastw_q   <= lastw_d;
    cnt_q     <= cnt_d;
    prev_q    <= prev_d;
    hash_q    <= hash_d;
  end

  assign hash_value_o = hash_q;

  dhash_bins #(
    .DEPTH (P),
    .AW    (AW),
    .DW    (SUMW)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dhash_div #(
    .DVD_W (SUMW),
    .DVS_W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mem_rdata),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/dhash_bins.sv
`default_nettype none

module dhash_bins #(
  parameter int unsigned DEPTH = 72,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 26
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dhash_div.sv
`default_nettype none

module dhash_div #(
  parameter int unsigned DVD_W = 26,
  parameter int unsigned DVS_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned SW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [SW-1:0]    step_q, step_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   shift_rem;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step per cycle, quotient bits shift in behind the dividend
  always_comb begin
    shift_rem = {rem_q, quo_q[DVD_W-1]};
    diff      = shift_rem - {1'b0, dvs_q};
    ge        = (shift_rem >= {1'b0, dvs_q});
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    step_d    = step_q;
    run_d     = run_q;
    done_d    = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = SW'(DVD_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      quo_d  = DVD_W'({quo_q, ge});
      rem_d  = ge ? diff[DVS_W-1:0] : shift_rem[DVS_W-1:0];
      step_d = step_q - 1'b1;
      if (step_q == SW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dhash_chk.sv
`default_nettype none

`include "difference_hash_box_downsample_defines.svh"

module dhash_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic start,
  input logic busy,
  input logic hash_valid_o
);

  // The hash only shows while no pixel can be taken
  `DHBD_ASSERT_SAME(a_hash_while_busy, hash_valid_o, busy, "hash shown while accepting pixels")

  // The hash lasts exactly one cycle
  `DHBD_ASSERT_NEXT(a_hash_one_cycle, hash_valid_o, !hash_valid_o, "hash strobe held")

  // A register write restarts the image
  `DHBD_ASSERT_NEXT(a_cfg_restart, psel && penable && pwrite, busy, "no restart after write")

  // A pixel transfer never yields the hash in the next cycle
  `DHBD_ASSERT_NEXT(a_no_early_hash, start && !busy, !hash_valid_o, "hash too soon")

endmodule

bind difference_hash_box_downsample dhash_chk u_dhash_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .start        (start),
  .busy         (busy),
  .hash_valid_o (hash_valid_o)
);

`default_nettype wire

FILE: tb/difference_hash_box_downsample_checker.sv
module difference_hash_box_downsample_checker import dhash_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              start,
  input  logic              busy,
  input  logic [PIX_W-1:0]  gray_pixel_i,
  input  logic              hash_valid_o,
  input  logic [63:0]       hash_value_o,
  output int                fail_count,
  output int                pending_count,
  output int                hash_count
);

  localparam int unsigned COLS = DEF_GRID_COLUMNS;
  localparam int unsigned ROWS = DEF_GRID_ROWS;

  logic [CFG_W-1:0] width_reg, height_reg;
  int unsigned      col_pos, row_pos;
  longint unsigned  box_sums [ROWS][COLS];
  logic [63:0]      hash_q [$];

  initial begin
    fail_count = 0;
    hash_count = 0;
  end

  assign pending_count = hash_q.size();

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Span [lo, hi) of box k of n over size s, widened to one pixel
  task automatic box_edges(input int unsigned k, n, s, output int unsigned lo, hi);
    lo = (k * s) / n;
    hi = ((k + 1) * s) / n;
    if (hi <= lo) hi = lo + 1;
    if (hi > s) hi = s;
  endtask

  function automatic void clear_image();
    col_pos = 0;
    row_pos = 0;
    foreach (box_sums[j, i]) box_sums[j][i] = 0;
  endfunction

  // Accumulate one pixel; queue the hash when it completes the image
  task automatic take_pixel(input logic [PIX_W-1:0] pix);
    int unsigned     w, h, xl, xh, yl, yh;
    bit              in_col [COLS];
    longint unsigned avg [ROWS][COLS];
    logic [63:0]     hash;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    for (int i = 0; i < COLS; i++) begin
      box_edges(i, COLS, w, xl, xh);
      in_col[i] = (col_pos >= xl) && (col_pos < xh);
    end
    for (int j = 0; j < ROWS; j++) begin
      box_edges(j, ROWS, h, yl, yh);
      if (row_pos >= yl && row_pos < yh)
        for (int i = 0; i < COLS; i++)
          if (in_col[i]) box_sums[j][i] += pix;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) begin
      for (int j = 0; j < ROWS; j++) begin
        box_edges(j, ROWS, h, yl, yh);
        for (int i = 0; i < COLS; i++) begin
          box_edges(i, COLS, w, xl, xh);
          avg[j][i] = box_sums[j][i] / ((xh - xl) * (yh - yl));
        end
      end
      hash = '0;
      for (int j = 0; j < ROWS; j++)
        for (int i = 0; i + 1 < COLS; i++)
          hash = {hash[62:0], avg[j][i] > avg[j][i+1]};
      hash_q.push_back(hash);
      clear_image();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = 1;
      height_reg = 1;
      clear_image();
      hash_q.delete();
    end else begin
      // Register write restarts the image
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_e'(paddr[2]) == REG_IMAGE_WIDTH) width_reg = pwdata[CFG_W-1:0];
        else height_reg = pwdata[CFG_W-1:0];
        clear_image();
      end
      if (start && !busy) take_pixel(gray_pixel_i);
      // Compare each hash transfer with the oldest expectation
      if (hash_valid_o) begin
        hash_count++;
        if (hash_q.size() == 0) report($sformatf("unexpected hash %h", hash_value_o));
        else begin
          logic [63:0] want;
          want = hash_q.pop_front();
          if (hash_value_o !== want)
            report($sformatf("hash_value got %h want %h", hash_value_o, want));
        end
      end
    end
  end

endmodule

FILE: tb/difference_hash_box_downsample_tb.sv
module difference_hash_box_downsample_tb;
  import dhash_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 2300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [PIX_W-1:0]  gray_pixel_i = '0;
  logic              hash_valid_o;
  logic [63:0]       hash_value_o;
  int                fail_count, pending_count, hash_count;
  int                pixels_sent = 0;
  int unsigned       gap_pct = 0;

  always #4 clk_i = ~clk_i;

  difference_hash_box_downsample i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .gray_pixel_i, .hash_valid_o, .hash_value_o
  );

  difference_hash_box_downsample_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .start, .busy, .gray_pixel_i, .hash_valid_o, .hash_value_o,
    .fail_count, .pending_count, .hash_count
  );

  function automatic int unsigned eff_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return v;
  endfunction

  task automatic apb_write(input reg_idx_e idx, input int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Let the block drain, then write both size registers while idle
  task automatic set_size(input int unsigned w, h);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apb_write(REG_IMAGE_WIDTH, w);
    while (busy) @(posedge clk_i);
    apb_write(REG_IMAGE_HEIGHT, h);
  endtask

  // Hold start high until the transfer is taken
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start        <= 1'b1;
    gray_pixel_i <= v;
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_pixel(PIX_W'($urandom));
  endtask

  initial begin
    int unsigned w, h;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-pixel images at the value extremes
    send_pixel(8'h00);
    send_pixel(8'hFF);
    // Zero sizes are taken as one
    set_size(0, 0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    // Partial image dropped by a register write
    set_size(3, 2);
    send_pixels(3);
    set_size(3, 2);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    // Tall narrow image, boxes overlap in columns
    set_size(2, 5);
    send_pixels(10);

    // Random part: mostly small images
    gap_pct = 23;
    while (pixels_sent < 1800) begin
      case ($urandom_range(9))
        0:       begin w = $urandom_range(13, 60); h = $urandom_range(1, 4); end
        1:       begin w = $urandom_range(1);      h = $urandom_range(1); end
        default: begin w = $urandom_range(0, 12);  h = $urandom_range(0, 12); end
      endcase
      gap_pct = (pixels_sent < 600) ? 23 : (pixels_sent < 1200) ? 83 : 0;
      set_size(w, h);
      repeat ($urandom_range(1, 3)) send_pixels(eff_dim(w) * eff_dim(h));
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) $display("difference_hash_box_downsample_tb: PASS");
    else $display("difference_hash_box_downsample_tb: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("difference_hash_box_downsample_tb: FAIL");
    $finish;
  end

endmodule
